### rtl/core/rrca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reorder receiver package
// Shared widths, limits and type definitions for the reorder receiver.
// ----------------------------------------------------------------------------
package rrca_pkg;

	// Field widths of the packet header and of the result.
	localparam int SEQ_W = 32;
	localparam int LEN_W = 11;
	localparam int TAG_W = 8;
	localparam int CNT_W = 32;

	// Payload limits applied to every incoming packet.
	localparam int unsigned MAX_PAYLOAD = 1024;
	localparam int unsigned TAG_COUNT   = 256;

	// Connection phase.
	typedef enum logic [1:0] {
		PH_LISTEN = 2'd0,
		PH_AWAIT  = 2'd1,
		PH_DATA   = 2'd2,
		PH_CLOSED = 2'd3
	} phase_t;

	// Kind of a result transaction.
	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_SYNACK  = 2'd2,
		KIND_FINACK  = 2'd3
	} kind_t;

	// Sequencer state.
	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

endpackage

### rtl/core/reorder_receiver_cumulative_ack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reorder receiver with cumulative acknowledgement
// An item that gives one result or none is accepted, and its result
// sits in the output register on the next cycle; with a free output such items
// flow at one per cycle. An in-order packet that releases k buffered packets
// gives its first delivery, then one slot per cycle while the output is free,
// read from the single read port of the reorder buffer, then the ACK. Reset clears
// phase, counters and slot valid bits at once and sets the expected sequence number to 1.
// ----------------------------------------------------------------------------
module reorder_receiver_cumulative_ack #(
	parameter int WINDOW = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rrca_pkg::SEQ_W-1:0]   seq_number,
	input  logic                         syn_flag,
	input  logic                         ack_flag,
	input  logic                         fin_flag,
	input  logic                         checksum_ok,
	input  logic [rrca_pkg::LEN_W-1:0]   payload_length,
	input  logic [rrca_pkg::TAG_W-1:0]   payload_tag,

	output logic                         out_valid,
	input  logic                         out_stall,
	output rrca_pkg::kind_t              result_kind,
	output logic [rrca_pkg::SEQ_W-1:0]   ack_number,
	output logic [rrca_pkg::TAG_W-1:0]   deliver_tag,
	output logic [rrca_pkg::LEN_W-1:0]   deliver_length,
	output logic                         last_result,
	output logic [rrca_pkg::CNT_W-1:0]   packets_received,
	output logic [rrca_pkg::CNT_W-1:0]   out_of_order_count
);
	import rrca_pkg::*;

	localparam int SW = $clog2(WINDOW);
	localparam int NW = $clog2(WINDOW + 1);

	// Control state.
	state_t              state_q, state_d;
	phase_t              phase_q, phase_d;
	logic [SEQ_W-1:0]    expected_q;
	logic [SW-1:0]       exp_slot_q, exp_slot_d;
	logic [NW-1:0]       n_q;
	logic [WINDOW-1:0]   slot_valid_q;
	logic [CNT_W-1:0]    recv_q, reorder_q;

	// Reorder buffer payload storage and its registered read port.
	logic [LEN_W-1:0]    len_mem [WINDOW];
	logic [TAG_W-1:0]    tag_mem [WINDOW];
	logic [LEN_W-1:0]    rd_len_q;
	logic [TAG_W-1:0]    rd_tag_q;

	// Output register.
	logic                out_valid_q;
	kind_t               kind_q;
	logic [SEQ_W-1:0]    ack_q;
	logic [TAG_W-1:0]    tag_q;
	logic [LEN_W-1:0]    len_q;
	logic                last_q;

	// Tag reduction table, built at elaboration.
	logic [TAG_W-1:0]    tag_tbl [2**TAG_W];

	for (genvar g = 0; g < 2**TAG_W; g++) begin : g_tag_tbl
		assign tag_tbl[g] = TAG_W'(g % TAG_COUNT);
	end

	// Handshake helpers.
	logic load_ok, in_acc;
	assign load_ok = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !load_ok;
	assign in_acc = in_valid && !in_stall;

	// Packet classification against the expected sequence number.
	logic [LEN_W-1:0]    len_fix;
	logic [TAG_W-1:0]    tag_fix;
	logic [SEQ_W-1:0]    diff, exp_inc, exp_dec, seq_inc;
	logic                is_data, is_fin, in_order, ahead, in_win;
	logic [SW:0]         slot_sum;
	logic [SW-1:0]       wr_slot, slot_inc;
	logic                drain_more;

	assign len_fix  = (32'(payload_length) > 32'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
	                                                             : payload_length;
	assign tag_fix  = tag_tbl[payload_tag];
	assign is_fin   = (phase_q == PH_DATA) && checksum_ok && fin_flag;
	assign is_data  = (phase_q == PH_DATA) && checksum_ok && !fin_flag;
	assign in_order = seq_number == expected_q;
	assign ahead    = seq_number > expected_q;
	assign diff     = seq_number - expected_q;
	assign in_win   = diff < 32'(WINDOW);
	assign exp_inc  = expected_q + 1'b1;
	assign exp_dec  = expected_q - 1'b1;
	assign seq_inc  = seq_number + 1'b1;

	// Slot of a future packet: expected slot plus distance, wrapped once.
	assign slot_sum = {1'b0, exp_slot_q} + {1'b0, diff[SW-1:0]};
	assign wr_slot  = (slot_sum >= (SW+1)'(WINDOW)) ? SW'(slot_sum - (SW+1)'(WINDOW))
	                                                : SW'(slot_sum);
	// The next expected slot returns to zero when the window or the sequence space wraps.
	assign slot_inc = ((exp_slot_q == SW'(WINDOW - 1)) || (exp_inc == '0)) ? '0
	                                                                        : exp_slot_q + 1'b1;

	// Another buffered successor is ready and the result budget is not spent.
	assign drain_more = slot_valid_q[exp_slot_q] && (n_q < NW'(WINDOW));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && is_data && in_order) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (load_ok && !drain_more) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath control: result to load and state updates.
	logic                load, adv, recv_inc, reord_inc, slot_wr, slot_clr, n_start;
	kind_t               ld_kind;
	logic [SEQ_W-1:0]    ld_ack;
	logic [TAG_W-1:0]    ld_tag;
	logic [LEN_W-1:0]    ld_len;
	logic                ld_last;

	always_comb begin
		load      = 1'b0;
		adv       = 1'b0;
		recv_inc  = 1'b0;
		reord_inc = 1'b0;
		slot_wr   = 1'b0;
		slot_clr  = 1'b0;
		n_start   = 1'b0;
		phase_d   = phase_q;
		ld_kind   = KIND_ACK;
		ld_ack    = '0;
		ld_tag    = '0;
		ld_len    = '0;
		ld_last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (phase_q)
						PH_LISTEN: begin
							if (syn_flag) begin
								load    = 1'b1;
								ld_kind = KIND_SYNACK;
								ld_ack  = seq_inc;
								ld_last = 1'b1;
								phase_d = PH_AWAIT;
							end else begin
								phase_d = PH_DATA;
							end
						end
						PH_AWAIT: phase_d = PH_DATA;
						PH_DATA: begin
							if (is_fin) begin
								load    = 1'b1;
								ld_kind = KIND_FINACK;
								ld_ack  = seq_inc;
								ld_last = 1'b1;
								phase_d = PH_CLOSED;
							end else if (is_data) begin
								recv_inc = 1'b1;
								load     = 1'b1;
								if (in_order) begin
									ld_kind = KIND_DELIVER;
									ld_tag  = tag_fix;
									ld_len  = len_fix;
									adv     = 1'b1;
									n_start = 1'b1;
								end else begin
									ld_kind = KIND_ACK;
									ld_ack  = exp_dec;
									ld_last = 1'b1;
									if (ahead) begin
										reord_inc = 1'b1;
										slot_wr   = in_win;
									end
								end
							end
						end
						PH_CLOSED: ;
						default: ;
					endcase
				end
			end
			ST_DRAIN: begin
				if (load_ok) begin
					load = 1'b1;
					if (drain_more) begin
						ld_kind  = KIND_DELIVER;
						ld_tag   = rd_tag_q;
						ld_len   = rd_len_q;
						adv      = 1'b1;
						slot_clr = 1'b1;
					end else begin
						ld_kind = KIND_ACK;
						ld_ack  = exp_dec;
						ld_last = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign exp_slot_d = adv ? slot_inc : exp_slot_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_LISTEN;
			expected_q   <= SEQ_W'(1);
			exp_slot_q   <= SW'(1 % WINDOW);
			n_q          <= '0;
			slot_valid_q <= '0;
			recv_q       <= '0;
			reorder_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			exp_slot_q <= exp_slot_d;
			if (adv) expected_q <= exp_inc;
			if (n_start) n_q <= NW'(1);
			else if (slot_clr) n_q <= n_q + 1'b1;
			if (slot_wr) slot_valid_q[wr_slot] <= 1'b1;
			if (slot_clr) slot_valid_q[exp_slot_q] <= 1'b0;
			if (recv_inc) recv_q <= recv_q + 1'b1;
			if (reord_inc) reorder_q <= reorder_q + 1'b1;
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= ld_kind;
			ack_q  <= ld_ack;
			tag_q  <= ld_tag;
			len_q  <= ld_len;
			last_q <= ld_last;
		end
	end

	// Reorder buffer: one write port, one registered read port at the next slot.
	always_ff @(posedge clk) begin
		if (slot_wr) begin
			len_mem[wr_slot] <= len_fix;
			tag_mem[wr_slot] <= tag_fix;
		end
		rd_len_q <= len_mem[exp_slot_d];
		rd_tag_q <= tag_mem[exp_slot_d];
	end

	assign out_valid          = out_valid_q;
	assign result_kind        = kind_q;
	assign ack_number         = ack_q;
	assign deliver_tag        = tag_q;
	assign deliver_length     = len_q;
	assign last_result        = last_q;
	assign packets_received   = recv_q;
	assign out_of_order_count = reorder_q;

	// The drain never emits more deliveries than the window allows.
	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> n_q <= NW'(WINDOW))
		else $error("drain count exceeds window");

	// The expected slot index stays inside the window.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		exp_slot_q <= SW'(WINDOW - 1))
		else $error("expected slot out of range");

	// While draining, the held result is never the closing ACK.
	a_drain_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && out_valid_q) |-> !last_q)
		else $error("last result held during drain");

	// An in-order packet is delivered on the following cycle.
	a_inorder_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && state_d == ST_DRAIN) |=>
			(out_valid_q && kind_q == KIND_DELIVER && !last_q))
		else $error("in-order packet not delivered");

	// A slot that has been drained is released.
	a_slot_release: assert property (@(posedge clk) disable iff (!arst_n)
		slot_clr |=> !slot_valid_q[$past(exp_slot_q)])
		else $error("drained slot still valid");

endmodule
